// File: hdl/weekly_daily_alarm_table_core_defines.svh
// Assertion helpers for the alarm table core.
// Every property is clocked on clk and disabled while rst_n is low.
`ifndef WEEKLY_DAILY_ALARM_TABLE_CORE_DEFINES_SVH
`define WEEKLY_DAILY_ALARM_TABLE_CORE_DEFINES_SVH

// Same-cycle implication.
`define WDAT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WDAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/wdat_pkg.sv
package wdat_pkg;

    localparam int MAX_ALARMS = 16;
    localparam int IDX_W      = $clog2(MAX_ALARMS);
    localparam int CNT_W      = $clog2(MAX_ALARMS + 1);

    localparam logic [3:0] MAX_DAY    = 4'd6;
    localparam logic [4:0] MAX_HOUR   = 5'd23;
    localparam logic [5:0] MAX_MINUTE = 6'd59;
    localparam logic [31:0] REFIRE_GAP = 32'd59;

    localparam logic [1:0] KIND_DAILY  = 2'd0;
    localparam logic [1:0] KIND_WEEKLY = 2'd1;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] id;
    } wdat_entry_t;

    localparam int ENTRY_W = $bits(wdat_entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } wdat_state_t;

endpackage

// File: hdl/wdat_ram.sv
module wdat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/weekly_daily_alarm_table_core.sv
// Daily/weekly alarm table. An add transaction (tuser = 0) stores one alarm
// after range checks and table-full check, and answers with one result in
// the next cycle. A tick transaction (tuser = 1) scans the stored entries in
// the order they were added, one entry per cycle unless a second firing waits
// on a stalled output, through the registered read port of the entry and
// last-fire-time memories, and answers with one result per fired entry (last
// one marked by tlast) or a single no-fire result. A tick is accepted, then
// scanned entry by entry, then ends with the final result. No new transaction
// is taken during a scan.
`include "weekly_daily_alarm_table_core_defines.svh"

module weekly_daily_alarm_table_core (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] alarm_kind, [5:2] alarm_day, [10:6] alarm_hour, [16:11] alarm_minute,
    // [32:17] alarm_id, [35:33] now_weekday, [40:36] now_hour,
    // [46:41] now_minute, [78:47] now_seconds, [79] zero
    input  logic [wdat_pkg::IN_TDATA_W-1:0] s_tdata,
    // [0] func
    input  logic        s_tuser,
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] accepted, [1] fired, [17:2] fired_id, [23:18] zero
    output logic [wdat_pkg::OUT_TDATA_W-1:0] m_tdata,
    // [0] answer_kind
    output logic        m_tuser,
    output logic        m_tlast
);

    localparam int IDX_W = wdat_pkg::IDX_W;
    localparam int CNT_W = wdat_pkg::CNT_W;

    // Input field unpacking
    logic [1:0]  in_kind;
    logic [3:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [15:0] in_id;
    logic [2:0]  in_now_wday;
    logic [4:0]  in_now_hour;
    logic [5:0]  in_now_minute;
    logic [31:0] in_now_secs;

    assign in_kind       = s_tdata[1:0];
    assign in_day        = s_tdata[5:2];
    assign in_hour       = s_tdata[10:6];
    assign in_minute     = s_tdata[16:11];
    assign in_id         = s_tdata[32:17];
    assign in_now_wday   = s_tdata[35:33];
    assign in_now_hour   = s_tdata[40:36];
    assign in_now_minute = s_tdata[46:41];
    assign in_now_secs   = s_tdata[78:47];

    // State
    wdat_pkg::wdat_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] cur_reg, cur_next;       // entry whose data is on the RAM outputs
    logic             pend_reg, pend_next;     // a fired result is held back
    logic [15:0]      pend_id_reg, pend_id_next;

    // Tick time, held for the whole scan
    logic [2:0]  now_wday_reg;
    logic [4:0]  now_hour_reg;
    logic [5:0]  now_minute_reg;
    logic [31:0] now_secs_reg;
    logic        now_load;

    // Output register
    logic        out_vld_reg;
    logic        out_kind_reg, out_acc_reg, out_fired_reg, out_last_reg;
    logic [15:0] out_id_reg;
    logic        out_load;
    logic        out_kind_next, out_acc_next, out_fired_next, out_last_next;
    logic [15:0] out_id_next;
    logic        out_free;

    // Memory ports
    logic                  ent_we, lft_we, rd_en;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    wdat_pkg::wdat_entry_t ent_wdata, ent_rdata;
    logic [31:0]           lft_wdata, lft_rdata;

    logic s_accept;
    logic add_ok;
    logic match;
    logic [31:0] since_fire;
    logic fire;
    logic last_entry;
    logic stall;
    logic [CNT_W-1:0] cur_ext;

    wdat_ram #(
        .WIDTH (wdat_pkg::ENTRY_W),
        .DEPTH (wdat_pkg::MAX_ALARMS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (wr_addr),
        .wdata (ent_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ent_rdata)
    );

    wdat_ram #(
        .WIDTH (32),
        .DEPTH (wdat_pkg::MAX_ALARMS)
    ) u_lft_ram (
        .clk   (clk),
        .we    (lft_we),
        .waddr (wr_addr),
        .wdata (lft_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (lft_rdata)
    );

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    assign add_ok = (in_day <= wdat_pkg::MAX_DAY) && (in_hour <= wdat_pkg::MAX_HOUR) &&
                    (in_minute <= wdat_pkg::MAX_MINUTE) &&
                    (cnt_reg < CNT_W'(wdat_pkg::MAX_ALARMS));

    assign ent_wdata.kind   = in_kind;
    assign ent_wdata.day    = in_day[2:0];     // range checked above
    assign ent_wdata.hour   = in_hour;
    assign ent_wdata.minute = in_minute;
    assign ent_wdata.id     = in_id;

    // Scan evaluation of the entry on the RAM outputs
    always_comb
    begin
        case (ent_rdata.kind)
            wdat_pkg::KIND_DAILY:
                match = (ent_rdata.hour == now_hour_reg) &&
                        (ent_rdata.minute == now_minute_reg);
            wdat_pkg::KIND_WEEKLY:
                match = (ent_rdata.day == now_wday_reg) &&
                        (ent_rdata.hour == now_hour_reg) &&
                        (ent_rdata.minute == now_minute_reg);
            default:
                match = 1'b0;
        endcase
    end

    assign since_fire = now_secs_reg - lft_rdata;
    assign fire       = match && (since_fire > wdat_pkg::REFIRE_GAP);
    assign cur_ext    = CNT_W'(cur_reg);
    assign last_entry = (cur_ext + CNT_W'(1)) == cnt_reg;
    // a second firing must push the held one out first
    assign stall      = fire && pend_reg && !out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wdat_pkg::ST_IDLE:
            begin
                if (s_accept && (s_tuser == wdat_pkg::FUNC_TICK))
                begin
                    state_next = (cnt_reg == '0) ? wdat_pkg::ST_FLUSH : wdat_pkg::ST_SCAN;
                end
            end
            wdat_pkg::ST_SCAN:
            begin
                if (!stall && last_entry)
                begin
                    state_next = wdat_pkg::ST_FLUSH;
                end
            end
            wdat_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = wdat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wdat_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath control
    always_comb
    begin
        s_tready       = 1'b0;
        ent_we         = 1'b0;
        lft_we         = 1'b0;
        lft_wdata      = '0;
        wr_addr        = cnt_reg[IDX_W-1:0];
        rd_en          = 1'b0;
        rd_addr        = '0;
        now_load       = 1'b0;
        out_load       = 1'b0;
        out_kind_next  = wdat_pkg::FUNC_TICK;
        out_acc_next   = 1'b0;
        out_fired_next = 1'b0;
        out_id_next    = '0;
        out_last_next  = 1'b0;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        pend_next      = pend_reg;
        pend_id_next   = pend_id_reg;
        case (state_reg)
            wdat_pkg::ST_IDLE:
            begin
                s_tready = out_free;
                if (s_accept)
                begin
                    if (s_tuser == wdat_pkg::FUNC_ADD)
                    begin
                        ent_we        = add_ok;
                        lft_we        = add_ok;
                        out_load      = 1'b1;
                        out_kind_next = wdat_pkg::FUNC_ADD;
                        out_acc_next  = add_ok;
                        out_last_next = 1'b1;
                        if (add_ok)
                        begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        now_load  = 1'b1;
                        rd_en     = 1'b1;
                        rd_addr   = '0;
                        cur_next  = '0;
                        pend_next = 1'b0;
                    end
                end
            end
            wdat_pkg::ST_SCAN:
            begin
                wr_addr = cur_reg;
                if (!stall)
                begin
                    if (fire)
                    begin
                        lft_we       = 1'b1;
                        lft_wdata    = now_secs_reg;
                        pend_next    = 1'b1;
                        pend_id_next = ent_rdata.id;
                        if (pend_reg)
                        begin
                            out_load       = 1'b1;
                            out_fired_next = 1'b1;
                            out_id_next    = pend_id_reg;
                        end
                    end
                    if (!last_entry)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = cur_reg + IDX_W'(1);
                        cur_next = cur_reg + IDX_W'(1);
                    end
                end
            end
            wdat_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_fired_next = pend_reg;
                    out_id_next    = pend_reg ? pend_id_reg : 16'd0;
                    out_last_next  = 1'b1;
                    pend_next      = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= wdat_pkg::ST_IDLE;
            cnt_reg     <= '0;
            cur_reg     <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cur_reg   <= cur_next;
            pend_reg  <= pend_next;
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_id_reg <= pend_id_next;
        if (now_load)
        begin
            now_wday_reg   <= in_now_wday;
            now_hour_reg   <= in_now_hour;
            now_minute_reg <= in_now_minute;
            now_secs_reg   <= in_now_secs;
        end
        if (out_load)
        begin
            out_kind_reg  <= out_kind_next;
            out_acc_reg   <= out_acc_next;
            out_fired_reg <= out_fired_next;
            out_id_reg    <= out_id_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_id_reg, out_fired_reg, out_acc_reg};

    // Checks
    `WDAT_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(wdat_pkg::MAX_ALARMS),
        "entry count above table size")
    `WDAT_ASSERT_IMPL(a_scan_range, state_reg == wdat_pkg::ST_SCAN, cur_ext < cnt_reg,
        "scan index beyond stored entries")
    `WDAT_ASSERT_IMPL(a_busy_no_accept, state_reg != wdat_pkg::ST_IDLE, !s_tready,
        "transaction taken during a scan")
    `WDAT_ASSERT_IMPL(a_nofire_last,
        out_vld_reg && (!out_kind_reg || !out_fired_reg), out_last_reg,
        "add or no-fire result not marked last")
    `WDAT_ASSERT_NEXT(a_flush_clears,
        state_reg == wdat_pkg::ST_FLUSH && out_free, !pend_reg,
        "held firing survived end of scan")

endmodule
